### rtl/dpp_pkg.sv
// Package of the dual pattern puncturer: field widths, register indexes,
// reset values and the configuration struct. It depends on nothing.
`default_nettype none

package dpp_pkg;

   localparam int unsigned SymbolWidth   = 8;
   localparam int unsigned CsrIndexWidth = 3;
   localparam int unsigned CsrDataWidth  = 64;
   localparam int unsigned BlockLenWidth = 15;
   localparam int unsigned PatLenWidth   = 7;
   localparam int unsigned PatternWidth  = 64;
   localparam int unsigned PatIndexWidth = 6;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_BLOCK_LENGTH        = 3'd0,
      CSR_TAIL_LENGTH         = 3'd1,
      CSR_MAIN_PATTERN        = 3'd2,
      CSR_MAIN_PATTERN_LENGTH = 3'd3,
      CSR_TAIL_PATTERN        = 3'd4,
      CSR_TAIL_PATTERN_LENGTH = 3'd5
   } csr_index_type;

   localparam logic [BlockLenWidth-1:0] BlockLengthReset = 15'd64;
   localparam logic [BlockLenWidth-1:0] TailLengthReset  = 15'd0;
   localparam logic [PatternWidth-1:0]  PatternReset     = 64'd1;
   localparam logic [PatLenWidth-1:0]   PatLengthReset   = 7'd1;

   typedef struct packed {
      logic [BlockLenWidth-1:0] block_length;
      logic [BlockLenWidth-1:0] tail_length;
      logic [PatternWidth-1:0]  main_pattern;
      logic [PatLenWidth-1:0]   main_pattern_length;
      logic [PatternWidth-1:0]  tail_pattern;
      logic [PatLenWidth-1:0]   tail_pattern_length;
   } cfg_type;

endpackage

`default_nettype wire

### rtl/dpp_req_if.sv
// Input channel of the dual pattern puncturer: valid, ready and one symbol.
// It depends on dpp_pkg.
`default_nettype none

interface dpp_req_if;
   logic                               valid;
   logic                               ready;
   logic [dpp_pkg::SymbolWidth-1:0]    symbol_in;

   modport source (output valid, output symbol_in, input ready);
   modport sink   (input valid, input symbol_in, output ready);
endinterface

`default_nettype wire

### rtl/dpp_rsp_if.sv
// Result channel of the dual pattern puncturer: valid, ready and one symbol.
// It depends on dpp_pkg.
`default_nettype none

interface dpp_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [dpp_pkg::SymbolWidth-1:0]    symbol_out;

   modport source (output valid, output symbol_out, input ready);
   modport sink   (input valid, input symbol_out, output ready);
endinterface

`default_nettype wire

### rtl/dpp_csr_if.sv
// Configuration write channel of the dual pattern puncturer: valid, ready,
// register index and write data. It depends on dpp_pkg.
`default_nettype none

interface dpp_csr_if;
   logic                                 valid;
   logic                                 ready;
   logic [dpp_pkg::CsrIndexWidth-1:0]    index;
   logic [dpp_pkg::CsrDataWidth-1:0]     data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### rtl/dpp_csr.sv
// Configuration register file of the dual pattern puncturer.
// It depends on dpp_pkg and dpp_csr_if.
`default_nettype none

module dpp_csr (
   input  wire logic         clock,
   input  wire logic         reset,
   dpp_csr_if.sink           csr_if,
   output dpp_pkg::cfg_type  cfg
);

   dpp_pkg::cfg_type cfg_ff;
   dpp_pkg::cfg_type cfg_in;

   assign csr_if.ready = 1'b1;
   assign cfg          = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_if.valid) begin
         unique case (csr_if.index)
            dpp_pkg::CSR_BLOCK_LENGTH: begin
               cfg_in.block_length = csr_if.data[dpp_pkg::BlockLenWidth-1:0];
            end
            dpp_pkg::CSR_TAIL_LENGTH: begin
               cfg_in.tail_length = csr_if.data[dpp_pkg::BlockLenWidth-1:0];
            end
            dpp_pkg::CSR_MAIN_PATTERN: begin
               cfg_in.main_pattern = csr_if.data[dpp_pkg::PatternWidth-1:0];
            end
            dpp_pkg::CSR_MAIN_PATTERN_LENGTH: begin
               cfg_in.main_pattern_length = csr_if.data[dpp_pkg::PatLenWidth-1:0];
            end
            dpp_pkg::CSR_TAIL_PATTERN: begin
               cfg_in.tail_pattern = csr_if.data[dpp_pkg::PatternWidth-1:0];
            end
            dpp_pkg::CSR_TAIL_PATTERN_LENGTH: begin
               cfg_in.tail_pattern_length = csr_if.data[dpp_pkg::PatLenWidth-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.block_length        <= dpp_pkg::BlockLengthReset;
         cfg_ff.tail_length         <= dpp_pkg::TailLengthReset;
         cfg_ff.main_pattern        <= dpp_pkg::PatternReset;
         cfg_ff.main_pattern_length <= dpp_pkg::PatLengthReset;
         cfg_ff.tail_pattern        <= dpp_pkg::PatternReset;
         cfg_ff.tail_pattern_length <= dpp_pkg::PatLengthReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

### rtl/dpp_sched.sv
// Block position and pattern index counters with the keep decision.
// It depends on dpp_pkg.
`default_nettype none

module dpp_sched #(
   parameter int unsigned MAX_BLOCK_LEN   = 16384,
   parameter int unsigned MAX_PATTERN_LEN = 64
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire dpp_pkg::cfg_type  cfg,
   input  wire logic              advance,
   output logic                   keep
);

   localparam int unsigned PosWidth = $clog2(MAX_BLOCK_LEN);
   localparam int unsigned IdxWidth = (MAX_PATTERN_LEN > 1) ? $clog2(MAX_PATTERN_LEN) : 1;
   localparam int unsigned SumWidth =
      ((PosWidth > dpp_pkg::BlockLenWidth) ? PosWidth : dpp_pkg::BlockLenWidth) + 1;
   localparam int unsigned LenWidth = dpp_pkg::PatLenWidth + 1;
   localparam logic [SumWidth-1:0] MaxBlock   = SumWidth'(MAX_BLOCK_LEN);
   localparam logic [LenWidth-1:0] MaxPattern = LenWidth'(MAX_PATTERN_LEN);

   logic [PosWidth-1:0] pos_ff, pos_in;
   logic [IdxWidth-1:0] main_idx_ff, main_idx_in;
   logic [IdxWidth-1:0] tail_idx_ff, tail_idx_in;

   logic [SumWidth-1:0] blen;
   logic [SumWidth-1:0] blen_raw;
   logic [LenWidth-1:0] mlen, mlen_raw;
   logic [LenWidth-1:0] tlen, tlen_raw;
   logic [SumWidth-1:0] tail_sum;
   logic [SumWidth-1:0] pos_next;
   logic [LenWidth-1:0] main_next;
   logic [LenWidth-1:0] tail_next;
   logic                in_tail;

   always_comb begin
      blen_raw = SumWidth'(cfg.block_length);
      mlen_raw = LenWidth'(cfg.main_pattern_length);
      tlen_raw = LenWidth'(cfg.tail_pattern_length);

      if (blen_raw == '0) begin
         blen = SumWidth'(1);
      end else if (blen_raw > MaxBlock) begin
         blen = MaxBlock;
      end else begin
         blen = blen_raw;
      end

      if (mlen_raw == '0) begin
         mlen = LenWidth'(1);
      end else if (mlen_raw > MaxPattern) begin
         mlen = MaxPattern;
      end else begin
         mlen = mlen_raw;
      end

      if (tlen_raw == '0) begin
         tlen = LenWidth'(1);
      end else if (tlen_raw > MaxPattern) begin
         tlen = MaxPattern;
      end else begin
         tlen = tlen_raw;
      end

      tail_sum = SumWidth'(pos_ff) + SumWidth'(cfg.tail_length);
      in_tail  = (tail_sum >= blen);

      if (in_tail) begin
         keep = cfg.tail_pattern[dpp_pkg::PatIndexWidth'(tail_idx_ff)];
      end else begin
         keep = cfg.main_pattern[dpp_pkg::PatIndexWidth'(main_idx_ff)];
      end

      pos_next  = SumWidth'(pos_ff) + SumWidth'(1);
      main_next = LenWidth'(main_idx_ff) + LenWidth'(1);
      tail_next = LenWidth'(tail_idx_ff) + LenWidth'(1);

      pos_in      = pos_ff;
      main_idx_in = main_idx_ff;
      tail_idx_in = tail_idx_ff;
      if (advance) begin
         if (pos_next >= blen) begin
            pos_in      = '0;
            main_idx_in = '0;
            tail_idx_in = '0;
         end else begin
            pos_in      = pos_next[PosWidth-1:0];
            main_idx_in = (main_next >= mlen) ? '0 : main_next[IdxWidth-1:0];
            tail_idx_in = (tail_next >= tlen) ? '0 : tail_next[IdxWidth-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         main_idx_ff <= '0;
         tail_idx_ff <= '0;
      end else begin
         pos_ff      <= pos_in;
         main_idx_ff <= main_idx_in;
         tail_idx_ff <= tail_idx_in;
      end
   end

endmodule

`default_nettype wire

### rtl/dpp_out_buf.sv
// Two-entry result buffer, an output register with a skid register behind it.
// It depends on dpp_pkg and dpp_rsp_if.
`default_nettype none

module dpp_out_buf (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             push,
   input  wire logic [dpp_pkg::SymbolWidth-1:0]  push_data,
   output logic                                  full,
   dpp_rsp_if.source                             rsp_if
);

   logic                            out_valid_ff, out_valid_in;
   logic                            skid_valid_ff, skid_valid_in;
   logic [dpp_pkg::SymbolWidth-1:0] out_data_ff, out_data_in;
   logic [dpp_pkg::SymbolWidth-1:0] skid_data_ff, skid_data_in;
   logic                            pop;

   assign pop               = out_valid_ff && rsp_if.ready;
   assign full              = skid_valid_ff;
   assign rsp_if.valid      = out_valid_ff;
   assign rsp_if.symbol_out = out_data_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_data_in   = out_data_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!out_valid_ff || pop) begin
            out_data_in  = push_data;
            out_valid_in = 1'b1;
         end else begin
            skid_data_in  = push_data;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

endmodule

`default_nettype wire

### rtl/dual_pattern_puncturer.sv
// Top level of the dual pattern puncturer.
// It depends on dpp_pkg, the channel interfaces, dpp_csr, dpp_sched and dpp_out_buf.
//
// The block takes one symbol per cycle while input ready is high and keeps or
// drops it by the bit of the main or the tail keep pattern that its position
// within the block selects; a kept symbol goes to the output register, or to
// the skid register while that is held, and leaves from the output register.
// The position and pattern index counters advance on each accepted item. A
// two-entry result buffer lets input items flow while one result waits; input
// ready drops only when both entries are full. Configuration writes are always
// accepted and take effect on the next item.
`default_nettype none

module dual_pattern_puncturer #(
   parameter int unsigned MAX_BLOCK_LEN   = 16384,
   parameter int unsigned MAX_PATTERN_LEN = 64
) (
   input  wire logic  clock,
   input  wire logic  reset,
   dpp_req_if.sink    req_if,
   dpp_rsp_if.source  rsp_if,
   dpp_csr_if.sink    csr_if
);

   dpp_pkg::cfg_type cfg;
   logic             accept;
   logic             keep;
   logic             full;

   assign req_if.ready = !full;
   assign accept       = req_if.valid && !full;

   dpp_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_if (csr_if),
      .cfg    (cfg)
   );

   dpp_sched #(
      .MAX_BLOCK_LEN   (MAX_BLOCK_LEN),
      .MAX_PATTERN_LEN (MAX_PATTERN_LEN)
   ) u_sched (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .advance (accept),
      .keep    (keep)
   );

   dpp_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (accept && keep),
      .push_data (req_if.symbol_in),
      .full      (full),
      .rsp_if    (rsp_if)
   );

endmodule

`default_nettype wire
